@@ src/boc_pkg.sv @@
// ----------------------------------------------------------------------------
// boc_pkg
// Shared widths, codes and the shape record for the broadcast offset block.
// ----------------------------------------------------------------------------
package boc_pkg;

    localparam int IDX_W        = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int RANK_CAP     = 4;
    localparam int MAX_RANK_DEF = 4;
    localparam int DIM_BITS_DEF = 16;
    localparam int DIV_STEP     = 4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_TOO_BIG = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_LEFT_DIMS  = 2'd0,
        CFG_RIGHT_DIMS = 2'd1,
        CFG_LEFT_RANK  = 2'd2,
        CFG_RIGHT_RANK = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                               fits;
        logic                               big;
        logic [IDX_W-1:0]                   count;
        logic [RANK_CAP-1:0]                l_live;
        logic [RANK_CAP-1:0]                r_live;
        logic [RANK_CAP-1:0][IDX_W-1:0]     l_stride;
        logic [RANK_CAP-1:0][IDX_W-1:0]     r_stride;
    } shape_t;

endpackage

@@ src/broadcast_offset_calculator_unit.sv @@
// throughput: one item per cycle while out_ready stays high, set by the divider pipeline per dimension
// each divider stage resolves four quotient bits of the 32-bit index
// reset: configuration registers clear to zero and all stage valid bits drop
// ----------------------------------------------------------------------------
// broadcast_offset_calculator_unit
// Broadcast address generator: flat result index to left and right operand
// offsets, with element count and status.
// ----------------------------------------------------------------------------
module broadcast_offset_calculator_unit
    import boc_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF,
    parameter int DIM_BITS = DIM_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IDX_W-1:0]      flat_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [IDX_W-1:0]      left_offset,
    output logic [IDX_W-1:0]      right_offset,
    output logic [IDX_W-1:0]      result_count,
    output logic [1:0]            status,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW = IDX_W + MAX_RANK*DIM_BITS;

    shape_t                             shape;
    logic [MAX_RANK-1:0][DIM_BITS-1:0]  div_dims;
    logic [MAX_RANK-1:0][DIM_BITS-1:0]  coord;

    logic             valid_a [MAX_RANK];
    logic             ready_a [MAX_RANK];
    logic [IDX_W-1:0] num_a   [MAX_RANK];
    logic [SW-1:0]    side_a  [MAX_RANK];

    boc_shape #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .shape     (shape),
        .div_dims  (div_dims)
    );

    assign valid_a[0] = in_valid;
    assign num_a[0]   = flat_index;
    assign side_a[0]  = {flat_index, {(MAX_RANK*DIM_BITS){1'b0}}};
    assign in_ready   = ready_a[0];

    genvar j;
    generate
        for (j = 0; j < MAX_RANK-1; j++)
        begin : g_div
            logic [DIM_BITS-1:0] rem;
            logic [SW-1:0]       side_out;

            boc_div #(
                .DIM_BITS (DIM_BITS),
                .SW       (SW)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (valid_a[j]),
                .in_ready  (ready_a[j]),
                .in_num    (num_a[j]),
                .in_side   (side_a[j]),
                .divisor   (div_dims[j]),
                .out_valid (valid_a[j+1]),
                .out_ready (ready_a[j+1]),
                .out_quo   (num_a[j+1]),
                .out_rem   (rem),
                .out_side  (side_out)
            );

            assign side_a[j+1] = side_out | (SW'(rem) << (j*DIM_BITS));
            assign coord[j]    = side_a[MAX_RANK-1][j*DIM_BITS +: DIM_BITS];
        end
    endgenerate

    // innermost remainder chain ends with the outermost coordinate
    assign coord[MAX_RANK-1] = num_a[MAX_RANK-1][DIM_BITS-1:0];

    boc_off #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_off (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (valid_a[MAX_RANK-1]),
        .in_ready     (ready_a[MAX_RANK-1]),
        .idx          (side_a[MAX_RANK-1][SW-1 -: IDX_W]),
        .coord        (coord),
        .shape        (shape),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_offset  (left_offset),
        .right_offset (right_offset),
        .result_count (result_count),
        .status       (status)
    );

endmodule

@@ src/boc_shape.sv @@
// ----------------------------------------------------------------------------
// boc_shape
// Configuration registers and derived shape: broadcast dims, count, strides.
// ----------------------------------------------------------------------------
module boc_shape
    import boc_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF,
    parameter int DIM_BITS = DIM_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data,
    output shape_t                              shape,
    output logic [MAX_RANK-1:0][DIM_BITS-1:0]   div_dims
);

    logic [CFG_DATA_W-1:0] left_dims_reg;
    logic [CFG_DATA_W-1:0] right_dims_reg;
    logic [2:0]            left_rank_reg;
    logic [2:0]            right_rank_reg;

    logic [DIM_BITS-1:0] ld [MAX_RANK];
    logic [DIM_BITS-1:0] rd [MAX_RANK];
    logic [DIM_BITS-1:0] res [MAX_RANK];
    logic [MAX_RANK-1:0] fit_k;

    logic [IDX_W-1:0]    cnt_reg  [MAX_RANK];
    logic                big_reg  [MAX_RANK];
    logic [IDX_W-1:0]    lstr_reg [MAX_RANK];
    logic [IDX_W-1:0]    rstr_reg [MAX_RANK];

    logic [RANK_CAP-1:0][IDX_W-1:0] ls_pad;
    logic [RANK_CAP-1:0][IDX_W-1:0] rs_pad;
    logic [RANK_CAP-1:0]            ll_pad;
    logic [RANK_CAP-1:0]            rl_pad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dims_reg  <= '0;
            right_dims_reg <= '0;
            left_rank_reg  <= '0;
            right_rank_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LEFT_DIMS:  left_dims_reg  <= cfg_data;
                CFG_RIGHT_DIMS: right_dims_reg <= cfg_data;
                CFG_LEFT_RANK:  left_rank_reg  <= cfg_data[2:0];
                CFG_RIGHT_RANK: right_rank_reg <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_RANK; k++)
        begin : g_dim
            logic [IDX_W+DIM_BITS-1:0] prod;

            assign ld[k] = (3'(k) < left_rank_reg) ?
                           left_dims_reg[k*DIM_BITS +: DIM_BITS] : DIM_BITS'(1);
            assign rd[k] = (3'(k) < right_rank_reg) ?
                           right_dims_reg[k*DIM_BITS +: DIM_BITS] : DIM_BITS'(1);
            assign fit_k[k] = (ld[k] == rd[k]) || (ld[k] == DIM_BITS'(1)) ||
                              (rd[k] == DIM_BITS'(1));
            assign res[k] = (ld[k] == DIM_BITS'(1)) ? rd[k] : ld[k];
            assign div_dims[k] = (res[k] == '0) ? DIM_BITS'(1) : res[k];

            assign ls_pad[k] = lstr_reg[k];
            assign rs_pad[k] = rstr_reg[k];
            assign ll_pad[k] = (ld[k] != DIM_BITS'(1));
            assign rl_pad[k] = (rd[k] != DIM_BITS'(1));

            if (k == 0)
            begin : g_first
                assign prod = {{IDX_W{1'b0}}, res[k]};
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        cnt_reg[k]  <= '0;
                        big_reg[k]  <= 1'b0;
                        lstr_reg[k] <= '0;
                        rstr_reg[k] <= '0;
                    end
                    else
                    begin
                        cnt_reg[k]  <= prod[IDX_W-1:0];
                        big_reg[k]  <= 1'b0;
                        lstr_reg[k] <= IDX_W'(1);
                        rstr_reg[k] <= IDX_W'(1);
                    end
                end
            end
            else
            begin : g_next
                assign prod = {{DIM_BITS{1'b0}}, cnt_reg[k-1]} *
                              {{IDX_W{1'b0}}, res[k]};
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        cnt_reg[k]  <= '0;
                        big_reg[k]  <= 1'b0;
                        lstr_reg[k] <= '0;
                        rstr_reg[k] <= '0;
                    end
                    else
                    begin
                        cnt_reg[k]  <= prod[IDX_W-1:0];
                        big_reg[k]  <= big_reg[k-1] | (|prod[IDX_W+DIM_BITS-1:IDX_W]);
                        lstr_reg[k] <= lstr_reg[k-1] * {{(IDX_W-DIM_BITS){1'b0}}, ld[k-1]};
                        rstr_reg[k] <= rstr_reg[k-1] * {{(IDX_W-DIM_BITS){1'b0}}, rd[k-1]};
                    end
                end
            end
        end

        for (k = MAX_RANK; k < RANK_CAP; k++)
        begin : g_pad
            assign ls_pad[k] = '0;
            assign rs_pad[k] = '0;
            assign ll_pad[k] = 1'b0;
            assign rl_pad[k] = 1'b0;
        end
    endgenerate

    assign shape.fits     = &fit_k;
    assign shape.big      = big_reg[MAX_RANK-1];
    assign shape.count    = cnt_reg[MAX_RANK-1];
    assign shape.l_live   = ll_pad;
    assign shape.r_live   = rl_pad;
    assign shape.l_stride = ls_pad;
    assign shape.r_stride = rs_pad;

endmodule

@@ src/boc_div.sv @@
// ----------------------------------------------------------------------------
// boc_div
// Pipelined restoring divider, a few quotient bits per stage, with sideband.
// ----------------------------------------------------------------------------
module boc_div
    import boc_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEF,
    parameter int SW       = IDX_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IDX_W-1:0]    in_num,
    input  logic [SW-1:0]       in_side,
    input  logic [DIM_BITS-1:0] divisor,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    out_quo,
    output logic [DIM_BITS-1:0] out_rem,
    output logic [SW-1:0]       out_side
);

    localparam int NST = IDX_W / DIV_STEP;

    logic [NST-1:0]      v_reg;
    logic [NST-1:0]      en;
    logic [IDX_W-1:0]    num_reg  [NST];
    logic [DIM_BITS-1:0] rem_reg  [NST];
    logic [SW-1:0]       side_reg [NST];

    genvar i;
    generate
        for (i = 0; i < NST; i++)
        begin : g_stage
            logic                vin;
            logic [IDX_W-1:0]    n_in;
            logic [DIM_BITS-1:0] r_in;
            logic [SW-1:0]       s_in;
            logic [IDX_W-1:0]    n_out;
            logic [DIM_BITS-1:0] r_out;

            if (i == 0)
            begin : g_head
                assign vin  = in_valid;
                assign n_in = in_num;
                assign r_in = '0;
                assign s_in = in_side;
            end
            else
            begin : g_body
                assign vin  = v_reg[i-1];
                assign n_in = num_reg[i-1];
                assign r_in = rem_reg[i-1];
                assign s_in = side_reg[i-1];
            end

            if (i == NST-1)
            begin : g_tail_en
                assign en[i] = !v_reg[i] || out_ready;
            end
            else
            begin : g_mid_en
                assign en[i] = !v_reg[i] || en[i+1];
            end

            always_comb
            begin
                logic [DIM_BITS:0] t;
                n_out = n_in;
                r_out = r_in;
                for (int j = 0; j < DIV_STEP; j++)
                begin
                    t     = {r_out, n_out[IDX_W-1]};
                    n_out = {n_out[IDX_W-2:0], 1'b0};
                    if (t >= {1'b0, divisor})
                    begin
                        t        = t - {1'b0, divisor};
                        n_out[0] = 1'b1;
                    end
                    r_out = t[DIM_BITS-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (en[i])
                begin
                    v_reg[i] <= vin;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[i] && vin)
                begin
                    num_reg[i]  <= n_out;
                    rem_reg[i]  <= r_out;
                    side_reg[i] <= s_in;
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];
    assign out_quo   = num_reg[NST-1];
    assign out_rem   = rem_reg[NST-1];
    assign out_side  = side_reg[NST-1];

    // a stalled head stage keeps its item
    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && !en[0]) |=> (v_reg[0] && $stable(num_reg[0])))
        else $error("head stage lost its item while stalled");

    // an accepted item lands in the head stage
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted item not captured");

    // a full pipe with a stalled output takes nothing new
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && !out_ready) |-> !in_ready)
        else $error("input taken while pipe full and stalled");

endmodule

@@ src/boc_off.sv @@
// ----------------------------------------------------------------------------
// boc_off
// Coordinate times stride products, status decision and offset sums.
// ----------------------------------------------------------------------------
module boc_off
    import boc_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF,
    parameter int DIM_BITS = DIM_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [IDX_W-1:0]                   idx,
    input  logic [MAX_RANK-1:0][DIM_BITS-1:0]  coord,
    input  shape_t                             shape,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [IDX_W-1:0]                   left_offset,
    output logic [IDX_W-1:0]                   right_offset,
    output logic [IDX_W-1:0]                   result_count,
    output logic [1:0]                         status
);

    logic             v1_reg;
    logic             v2_reg;
    logic             en1;
    logic             en2;
    logic [IDX_W-1:0] pl_reg [MAX_RANK];
    logic [IDX_W-1:0] pr_reg [MAX_RANK];
    status_t          st1_reg;
    logic [IDX_W-1:0] cnt1_reg;
    status_t          st1_next;
    logic [IDX_W-1:0] cnt1_next;

    logic [IDX_W-1:0] loff_reg;
    logic [IDX_W-1:0] roff_reg;
    logic [IDX_W-1:0] cnt2_reg;
    status_t          st2_reg;
    logic [IDX_W-1:0] loff_next;
    logic [IDX_W-1:0] roff_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        if (!shape.fits)
        begin
            st1_next  = ST_NO_FIT;
            cnt1_next = '0;
        end
        else if (shape.big)
        begin
            st1_next  = ST_TOO_BIG;
            cnt1_next = '1;
        end
        else if (idx >= shape.count)
        begin
            st1_next  = ST_RANGE;
            cnt1_next = shape.count;
        end
        else
        begin
            st1_next  = ST_OK;
            cnt1_next = shape.count;
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_RANK; k++)
        begin : g_prod
            always_ff @(posedge clk)
            begin
                if (en1 && in_valid)
                begin
                    pl_reg[k] <= shape.l_live[k] ?
                        {{(IDX_W-DIM_BITS){1'b0}}, coord[k]} * shape.l_stride[k] : '0;
                    pr_reg[k] <= shape.r_live[k] ?
                        {{(IDX_W-DIM_BITS){1'b0}}, coord[k]} * shape.r_stride[k] : '0;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            st1_reg  <= st1_next;
            cnt1_reg <= cnt1_next;
        end
    end

    always_comb
    begin
        loff_next = '0;
        roff_next = '0;
        for (int j = 0; j < MAX_RANK; j++)
        begin
            loff_next = loff_next + pl_reg[j];
            roff_next = roff_next + pr_reg[j];
        end
        if (st1_reg != ST_OK)
        begin
            loff_next = '0;
            roff_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            loff_reg <= loff_next;
            roff_reg <= roff_next;
            cnt2_reg <= cnt1_reg;
            st2_reg  <= st1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    assign out_valid    = v2_reg;
    assign left_offset  = loff_reg;
    assign right_offset = roff_reg;
    assign result_count = cnt2_reg;
    assign status       = st2_reg;

endmodule

@@ tb/broadcast_offset_calculator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_offset_calculator_unit_test
// Feeds flat result indices under a series of operand shapes and checks the
// left and right offsets, element count and status of every result item
// against an in-bench predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module broadcast_offset_calculator_unit_test;
    import boc_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] left_off;
        logic [IDX_W-1:0] right_off;
        logic [IDX_W-1:0] count;
        status_t          st;
    } offsets_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [IDX_W-1:0]      flat_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [IDX_W-1:0]      left_offset;
    logic [IDX_W-1:0]      right_offset;
    logic [IDX_W-1:0]      result_count;
    logic [1:0]            status;
    logic                  cfg_write = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [63:0]      shape_left_dims = '0;
    logic [63:0]      shape_right_dims = '0;
    logic [2:0]       shape_left_rank = '0;
    logic [2:0]       shape_right_rank = '0;

    logic [IDX_W-1:0] pending_indices[$];
    offsets_t         expected_offsets[$];
    int unsigned      send_idle = 0;
    int unsigned      recv_idle = 0;
    int unsigned      mismatches = 0;
    logic             hold_start = 1'b0;
    int unsigned      hold_left = 0;

    broadcast_offset_calculator_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .flat_index   (flat_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_offset  (left_offset),
        .right_offset (right_offset),
        .result_count (result_count),
        .status       (status),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] dim_at(logic [63:0] dims, logic [2:0] rank, int k);
        int r;
        begin
            r = (rank > 4) ? 4 : rank;
            if (k >= r)
                return 64'd1;
            return {48'd0, dims[k*16 +: 16]};
        end
    endfunction

    function automatic offsets_t broadcast_offsets(logic [IDX_W-1:0] idx);
        offsets_t    o;
        logic [63:0] ld[4];
        logic [63:0] rd[4];
        logic [63:0] res[4];
        logic [63:0] cnt, rem, lstr, rstr, loff, roff, d, c;
        bit          fits, big;
        begin
            cnt = 1; fits = 1; big = 0;
            lstr = 1; rstr = 1; loff = 0; roff = 0;
            for (int k = 0; k < 4; k++)
            begin
                ld[k] = dim_at(shape_left_dims, shape_left_rank, k);
                rd[k] = dim_at(shape_right_dims, shape_right_rank, k);
                if (ld[k] != rd[k] && ld[k] != 1 && rd[k] != 1)
                    fits = 0;
                res[k] = (ld[k] == 1) ? rd[k] : ld[k];
                cnt = cnt * res[k];
                if (cnt > 64'hFFFF_FFFF)
                begin
                    big = 1;
                    cnt = 64'h1_0000_0000;
                end
            end
            o.left_off = '0;
            o.right_off = '0;
            if (!fits)
            begin
                o.count = '0;
                o.st = ST_NO_FIT;
                return o;
            end
            if (big)
            begin
                o.count = 32'hFFFF_FFFF;
                o.st = ST_TOO_BIG;
                return o;
            end
            o.count = cnt[31:0];
            if ({32'd0, idx} >= cnt)
            begin
                o.st = ST_RANGE;
                return o;
            end
            rem = {32'd0, idx};
            for (int k = 0; k < 4; k++)
            begin
                d = (res[k] != 0) ? res[k] : 64'd1;
                c = rem % d;
                rem = rem / d;
                if (ld[k] != 1)
                    loff = loff + c * lstr;
                if (rd[k] != 1)
                    roff = roff + c * rstr;
                lstr = lstr * ld[k];
                rstr = rstr * rd[k];
            end
            o.left_off = loff[31:0];
            o.right_off = roff[31:0];
            o.st = ST_OK;
            return o;
        end
    endfunction

    task automatic enqueue_index(logic [IDX_W-1:0] v);
        begin
            pending_indices.insert(pending_indices.size(), v);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_indices.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                in_valid <= 1'b1;
                flat_index <= pending_indices.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= 400;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        begin
            $display("mismatch %s: got %h expected %h", what, got, want);
            mismatches++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        offsets_t e;
        if (rst_n && in_valid && in_ready)
            expected_offsets.insert(expected_offsets.size(), broadcast_offsets(flat_index));
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_offsets.size() == 0)
                report_mismatch("unexpected item", 32'd0, 32'd0);
            else
            begin
                e = expected_offsets.pop_front();
                if (left_offset !== e.left_off)
                    report_mismatch("left_offset", left_offset, e.left_off);
                if (right_offset !== e.right_off)
                    report_mismatch("right_offset", right_offset, e.right_off);
                if (result_count !== e.count)
                    report_mismatch("result_count", result_count, e.count);
                if (status !== e.st)
                    report_mismatch("status", {30'd0, status}, {30'd0, e.st});
            end
        end
    end

    task automatic wait_drained();
        begin
            do
                @(posedge clk);
            while (pending_indices.size() != 0 || in_valid || expected_offsets.size() != 0);
            repeat (30) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] data);
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            case (idx)
                CFG_LEFT_DIMS:  shape_left_dims = data;
                CFG_RIGHT_DIMS: shape_right_dims = data;
                CFG_LEFT_RANK:  shape_left_rank = data[2:0];
                CFG_RIGHT_RANK: shape_right_rank = data[2:0];
                default:        ;
            endcase
            @(posedge clk);
            cfg_write <= 1'b0;
        end
    endtask

    task automatic set_shapes(logic [63:0] ldims, logic [63:0] rdims,
                              logic [2:0] lrank, logic [2:0] rrank);
        logic [63:0] junk;
        begin
            wait_drained();
            junk = {$urandom, $urandom};
            write_reg(CFG_LEFT_DIMS, ldims);
            write_reg(CFG_RIGHT_DIMS, rdims);
            write_reg(CFG_LEFT_RANK, {junk[63:3], lrank});
            write_reg(CFG_RIGHT_RANK, {junk[34:0], junk[63:38], rrank});
        end
    endtask

    function automatic logic [15:0] random_dim();
        int unsigned p;
        begin
            p = $urandom_range(99);
            if (p < 25) return 16'd1;
            if (p < 80) return 16'($urandom_range(6, 2));
            if (p < 85) return 16'd0;
            if (p < 90) return 16'hFFFF;
            return 16'($urandom);
        end
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        offsets_t    o;
        int unsigned p;
        begin
            o = broadcast_offsets('0);
            p = $urandom_range(99);
            if (o.count != 0 && p < 85)
                return $urandom_range(o.count - 1);
            if (p < 90)
                return o.count;
            if (p < 93)
                return o.count + 1;
            return $urandom;
        end
    endfunction

    initial
    begin
        logic [63:0] ld, rd;
        logic [2:0]  lr, rr;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // scalar shapes straight out of reset
        enqueue_index(32'd0);
        enqueue_index(32'd1);
        enqueue_index(32'hFFFF_FFFF);

        // matching, broadcast, mismatch, zero dimension, overflow, oversize rank
        set_shapes(64'h0002_0003_0004_0005, 64'h0002_0001_0004_0001, 3'd4, 3'd4);
        enqueue_index(32'd0);
        enqueue_index(32'd119);
        enqueue_index(32'd120);
        enqueue_index(32'd57);
        set_shapes(64'h0000_0000_0003_0004, 64'h0000_0000_0000_0005, 3'd2, 3'd1);
        enqueue_index(32'd3);
        set_shapes(64'h0000_0000_0001_0000, 64'h0000_0000_0000_0001, 3'd2, 3'd2);
        enqueue_index(32'd0);
        set_shapes(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 3'd4);
        enqueue_index(32'hFFFF_FFFF);
        set_shapes(64'h0001_0001_0001_FFFF, 64'h0001_0001_FFFF_0001, 3'd5, 3'd2);
        enqueue_index(32'hFFFD_FFFF);
        enqueue_index(32'hFFFE_0000);
        set_shapes(64'h0003_0003_0003_0003, 64'h0003_0003_0003_0003, 3'd0, 3'd6);
        enqueue_index(32'd80);
        enqueue_index(32'd81);

        for (int phase = 0; phase < 16; phase++)
        begin
            ld = {random_dim(), random_dim(), random_dim(), random_dim()};
            rd = {random_dim(), random_dim(), random_dim(), random_dim()};
            for (int k = 0; k < 4; k++)
                if ($urandom_range(1))
                    rd[k*16 +: 16] = ld[k*16 +: 16];
            lr = 3'($urandom_range(4));
            rr = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4));
            set_shapes(ld, rd, lr, rr);
            case (phase % 4)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 88; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 88; end
                default: begin send_idle = 23; recv_idle = 23; end
            endcase
            for (int i = 0; i < 50; i++)
                enqueue_index(random_index());
            if (phase == 4)
            begin
                @(posedge clk);
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            // sender pauses until all results are in
            wait_drained();
            for (int i = 0; i < 50; i++)
                enqueue_index(random_index());
        end

        wait_drained();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
src/boc_pkg.sv
src/boc_shape.sv
src/boc_div.sv
src/boc_off.sv
src/broadcast_offset_calculator_unit.sv
tb/broadcast_offset_calculator_unit_test.sv
